// ----- rtl/stereo_channel_strip_ramped_macros.svh -----
// Assertion macros used by the port checker of the channel strip.
// Needs nothing but the file that includes it.
`ifndef STEREO_CHANNEL_STRIP_RAMPED_MACROS_SVH
`define STEREO_CHANNEL_STRIP_RAMPED_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SCSR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define SCSR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/scsr_pkg.sv -----
// Shared constants and types of the ramped stereo channel strip.
// Used by the top level and by its port checker.
package scsr_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int RAMP_BITS_DEF   = 12;

	// Width of the configuration data bus and of the ramped parameter values.
	localparam int CFG_W = 24;
	localparam int VAL_W = 26;
	localparam int NPAR  = 6;

	typedef logic signed [VAL_W-1:0] val_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_PRE_GAIN    = 3'd0;
	localparam logic [2:0] REG_PRE_PAN     = 3'd1;
	localparam logic [2:0] REG_POST_GAIN   = 3'd2;
	localparam logic [2:0] REG_POST_PAN    = 3'd3;
	localparam logic [2:0] REG_WIDTH       = 3'd4;
	localparam logic [2:0] REG_AUDIBLE     = 3'd5;
	localparam logic [2:0] REG_RAMP_FRAMES = 3'd6;
	localparam logic [2:0] REG_METER_DECAY = 3'd7;

	// Parameter slots of the ramp engine.
	localparam int P_PRE_GAIN  = 0;
	localparam int P_PRE_PAN   = 1;
	localparam int P_POST_GAIN = 2;
	localparam int P_POST_PAN  = 3;
	localparam int P_WIDTH     = 4;
	localparam int P_AUDIBLE   = 5;

	// Register reset values.
	localparam logic [23:0] RST_GAIN   = 24'd1048576;
	localparam logic [16:0] RST_PAN    = 17'd0;
	localparam logic [16:0] RST_WIDTH  = 17'd32768;
	localparam logic [15:0] RST_DECAY  = 16'd63813;
	localparam int          RST_RAMP   = 240;

	// Unity in Q1.15 and the width clamp limit.
	localparam val_t UNITY_Q15 = val_t'(32768);
	localparam val_t WIDTH_MAX = val_t'(65536);

	// Reset value of each ramped parameter.
	function automatic val_t par_reset(input int idx);
		val_t v;
		v = '0;
		case (idx) inside
			P_PRE_GAIN, P_POST_GAIN: v = val_t'(1048576);
			P_WIDTH, P_AUDIBLE:      v = UNITY_Q15;
			default:                 v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/stereo_channel_strip_ramped.sv -----
// Ramped stereo channel strip: pre gain and pan, mute, mid/side width, fader, pan, peak meter.
// Depends on scsr_pkg.
//
// One frame is taken at a time through a single shared signed multiplier driven by
// a small sequencer. When no ramp runs, the frame passes through the multiply and
// writeback steps into the output register, with two meter decay products more when
// the frame also ends a block. While a ramp runs, each of the six parameters is
// interpolated first with one multiply and a restoring divider that retires one
// quotient bit per cycle. The input stalls while a frame is in work; a new frame is
// taken while a finished result still waits in the output register.
module stereo_channel_strip_ramped #(
	parameter int SAMPLE_BITS = scsr_pkg::SAMPLE_BITS_DEF,
	parameter int RAMP_BITS   = scsr_pkg::RAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [scsr_pkg::CFG_W-1:0]    cfg_data,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	input  logic                          apply_targets,
	input  logic                          block_end,
	// Output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] pre_left,
	output logic signed [SAMPLE_BITS-1:0] pre_right,
	output logic signed [SAMPLE_BITS-1:0] post_left,
	output logic signed [SAMPLE_BITS-1:0] post_right,
	output logic [SAMPLE_BITS-1:0]        meter_left,
	output logic [SAMPLE_BITS-1:0]        meter_right,
	output logic                          meter_valid,
	output logic                          clipped
);

	localparam int VW = scsr_pkg::VAL_W;
	localparam int AW = SAMPLE_BITS + 12;
	localparam int PW = AW + VW;
	localparam int DW = 24 + RAMP_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int NP = scsr_pkg::NPAR;

	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_IMUL, S_IINIT, S_IDIV, S_IFIN, S_MUL, S_WB, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_L_GAIN, OP_R_GAIN, OP_L_PAN, OP_R_PAN, OP_PRE_L, OP_PRE_R, OP_WIDTH,
		OP_L_FADER, OP_R_FADER, OP_L_MUTE, OP_R_MUTE, OP_L_OPAN, OP_R_OPAN,
		OP_METER_L, OP_METER_R
	} op_t;

	// Configuration registers
	logic [23:0]          pre_gain_q, post_gain_q;
	logic [16:0]          pre_pan_q, post_pan_q, width_q;
	logic                 audible_q;
	logic [RAMP_BITS-1:0] ramp_frames_q;
	logic [15:0]          decay_q;

	// Ramp state
	scsr_pkg::val_t lat_q [NP];
	scsr_pkg::val_t start_q [NP];
	scsr_pkg::val_t cur_q [NP];
	logic [RAMP_BITS-1:0] rr_q;

	// Sequencer and datapath
	state_t                  state_q;
	op_t                     op_q;
	logic [2:0]              pidx_q;
	logic [CW-1:0]           cnt_q;
	logic [DW-1:0]           num_q;
	logic [RAMP_BITS-1:0]    rem_q;
	logic                    neg_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [AW-1:0]    l_q, r_q;
	logic signed [SAMPLE_BITS-1:0] pl_q, pr_q, ol_q, or_q;
	logic [SAMPLE_BITS-1:0]  peak_q [2];
	logic [SAMPLE_BITS-1:0]  level_q [2];
	logic                    be_q, clip_q;

	// Output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] o_pl_q, o_pr_q, o_ol_q, o_or_q;
	logic [SAMPLE_BITS-1:0]        o_ml_q, o_mr_q;
	logic                          o_mv_q, o_clip_q;

	// Targets taken from the registers, clamped
	scsr_pkg::val_t tgt [NP];
	scsr_pkg::val_t pre_pan_s, post_pan_s;
	logic           changed;

	always_comb begin
		pre_pan_s  = scsr_pkg::val_t'($signed(pre_pan_q));
		post_pan_s = scsr_pkg::val_t'($signed(post_pan_q));
		tgt[scsr_pkg::P_PRE_GAIN]  = scsr_pkg::val_t'({2'b00, pre_gain_q});
		tgt[scsr_pkg::P_POST_GAIN] = scsr_pkg::val_t'({2'b00, post_gain_q});
		tgt[scsr_pkg::P_PRE_PAN]   = (pre_pan_s > scsr_pkg::UNITY_Q15) ? scsr_pkg::UNITY_Q15 :
			(pre_pan_s < -scsr_pkg::UNITY_Q15) ? -scsr_pkg::UNITY_Q15 : pre_pan_s;
		tgt[scsr_pkg::P_POST_PAN]  = (post_pan_s > scsr_pkg::UNITY_Q15) ? scsr_pkg::UNITY_Q15 :
			(post_pan_s < -scsr_pkg::UNITY_Q15) ? -scsr_pkg::UNITY_Q15 : post_pan_s;
		tgt[scsr_pkg::P_WIDTH]     = (scsr_pkg::val_t'({9'd0, width_q}) > scsr_pkg::WIDTH_MAX) ?
			scsr_pkg::WIDTH_MAX : scsr_pkg::val_t'({9'd0, width_q});
		tgt[scsr_pkg::P_AUDIBLE]   = audible_q ? scsr_pkg::UNITY_Q15 : '0;
		changed = 1'b0;
		for (int i = 0; i < NP; i++) begin
			if (tgt[i] != lat_q[i]) changed = 1'b1;
		end
	end

	// Ramp length, clamped remaining count and interpolation step
	logic [RAMP_BITS-1:0] rlen, rr_new, rr_use, kstep;
	logic                 accept;

	assign accept = in_valid && !in_stall;
	assign rlen   = (ramp_frames_q == '0) ? RAMP_BITS'(1) : ramp_frames_q;
	assign rr_new = (apply_targets && changed) ? rlen : rr_q;
	assign rr_use = (rr_new > rlen) ? rlen : rr_new;
	assign kstep  = rlen - rr_q + RAMP_BITS'(1);

	// Pan factors: the positive side of a pan attenuates left, the negative side right
	function automatic scsr_pkg::val_t pan_l(input scsr_pkg::val_t p);
		return (p > 0) ? scsr_pkg::UNITY_Q15 - p : scsr_pkg::UNITY_Q15;
	endfunction

	function automatic scsr_pkg::val_t pan_r(input scsr_pkg::val_t p);
		return (p < 0) ? scsr_pkg::UNITY_Q15 + p : scsr_pkg::UNITY_Q15;
	endfunction

	// Operand selection for the shared multiplier
	logic signed [AW-1:0] mul_a;
	scsr_pkg::val_t       mul_b;
	logic signed [PW-1:0] mul_p;

	always_comb begin
		mul_a = l_q;
		mul_b = cur_q[scsr_pkg::P_PRE_GAIN];
		if (state_q == S_IMUL) begin
			mul_a = AW'(lat_q[pidx_q] - start_q[pidx_q]);
			mul_b = scsr_pkg::val_t'({{(VW - RAMP_BITS){1'b0}}, kstep});
		end else begin
			unique case (op_q)
				OP_L_GAIN:  begin mul_a = l_q; mul_b = cur_q[scsr_pkg::P_PRE_GAIN]; end
				OP_R_GAIN:  begin mul_a = r_q; mul_b = cur_q[scsr_pkg::P_PRE_GAIN]; end
				OP_L_PAN:   begin mul_a = l_q; mul_b = pan_l(cur_q[scsr_pkg::P_PRE_PAN]); end
				OP_R_PAN:   begin mul_a = r_q; mul_b = pan_r(cur_q[scsr_pkg::P_PRE_PAN]); end
				OP_PRE_L:   begin mul_a = l_q; mul_b = cur_q[scsr_pkg::P_AUDIBLE]; end
				OP_PRE_R:   begin mul_a = r_q; mul_b = cur_q[scsr_pkg::P_AUDIBLE]; end
				OP_WIDTH:   begin mul_a = l_q - r_q; mul_b = cur_q[scsr_pkg::P_WIDTH]; end
				OP_L_FADER: begin mul_a = l_q; mul_b = cur_q[scsr_pkg::P_POST_GAIN]; end
				OP_R_FADER: begin mul_a = r_q; mul_b = cur_q[scsr_pkg::P_POST_GAIN]; end
				OP_L_MUTE:  begin mul_a = l_q; mul_b = cur_q[scsr_pkg::P_AUDIBLE]; end
				OP_R_MUTE:  begin mul_a = r_q; mul_b = cur_q[scsr_pkg::P_AUDIBLE]; end
				OP_L_OPAN:  begin mul_a = l_q; mul_b = pan_l(cur_q[scsr_pkg::P_POST_PAN]); end
				OP_R_OPAN:  begin mul_a = r_q; mul_b = pan_r(cur_q[scsr_pkg::P_POST_PAN]); end
				OP_METER_L: begin
					mul_a = $signed({{(AW - SAMPLE_BITS){1'b0}}, level_q[0]});
					mul_b = scsr_pkg::val_t'({{(VW - 16){1'b0}}, decay_q});
				end
				OP_METER_R: begin
					mul_a = $signed({{(AW - SAMPLE_BITS){1'b0}}, level_q[1]});
					mul_b = scsr_pkg::val_t'({{(VW - 16){1'b0}}, decay_q});
				end
				default: begin mul_a = l_q; mul_b = cur_q[scsr_pkg::P_PRE_GAIN]; end
			endcase
		end
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	// Rounded rescaling of the registered product
	logic signed [PW-1:0] sh20, sh15, sum15, wid_l, wid_r;
	logic [SAMPLE_BITS-1:0] dec_v;

	assign sh20  = (prod_q + (PW'(1) <<< 19)) >>> 20;
	assign sh15  = (prod_q + (PW'(1) <<< 14)) >>> 15;
	assign sum15 = (PW'(l_q) + PW'(r_q)) <<< 15;
	assign wid_l = (sum15 + prod_q + (PW'(1) <<< 15)) >>> 16;
	assign wid_r = (sum15 - prod_q + (PW'(1) <<< 15)) >>> 16;
	assign dec_v = prod_q[SAMPLE_BITS+15:16];

	// Saturation of a rescaled value to the sample width
	logic signed [SAMPLE_BITS-1:0] sat_v;
	logic                          sat_c;
	logic [SAMPLE_BITS:0]          abs_w;
	logic [SAMPLE_BITS-1:0]        abs_v;

	always_comb begin
		sat_c = (sh15 > SAT_HI) || (sh15 < SAT_LO);
		if (sh15 > SAT_HI)      sat_v = SAT_HI[SAMPLE_BITS-1:0];
		else if (sh15 < SAT_LO) sat_v = SAT_LO[SAMPLE_BITS-1:0];
		else                    sat_v = sh15[SAMPLE_BITS-1:0];
		abs_w = sat_v[SAMPLE_BITS-1] ? -{sat_v[SAMPLE_BITS-1], sat_v} : {1'b0, sat_v};
		abs_v = abs_w[SAMPLE_BITS-1:0];
	end

	// Divider step and interpolated value
	logic [RAMP_BITS:0]   trial;
	logic                 qbit;
	logic signed [PW-1:0] prod_abs;
	scsr_pkg::val_t       quo_v, interp_v;

	assign trial    = {rem_q, num_q[DW-1]};
	assign qbit     = (trial >= {1'b0, rlen});
	assign prod_abs = prod_q[PW-1] ? -prod_q : prod_q;
	assign quo_v    = scsr_pkg::val_t'({1'b0, num_q[VW-2:0]});
	assign interp_v = neg_q ? start_q[pidx_q] - quo_v : start_q[pidx_q] + quo_v;

	assign in_stall = (state_q != S_IDLE);

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_gain_q    <= scsr_pkg::RST_GAIN;
			post_gain_q   <= scsr_pkg::RST_GAIN;
			pre_pan_q     <= scsr_pkg::RST_PAN;
			post_pan_q    <= scsr_pkg::RST_PAN;
			width_q       <= scsr_pkg::RST_WIDTH;
			audible_q     <= 1'b1;
			ramp_frames_q <= RAMP_BITS'(scsr_pkg::RST_RAMP);
			decay_q       <= scsr_pkg::RST_DECAY;
			for (int i = 0; i < NP; i++) begin
				lat_q[i]   <= scsr_pkg::par_reset(i);
				start_q[i] <= scsr_pkg::par_reset(i);
				cur_q[i]   <= scsr_pkg::par_reset(i);
			end
			rr_q        <= '0;
			state_q     <= S_IDLE;
			op_q        <= OP_L_GAIN;
			pidx_q      <= '0;
			cnt_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			neg_q       <= 1'b0;
			prod_q      <= '0;
			l_q         <= '0;
			r_q         <= '0;
			pl_q        <= '0;
			pr_q        <= '0;
			ol_q        <= '0;
			or_q        <= '0;
			peak_q[0]   <= '0;
			peak_q[1]   <= '0;
			level_q[0]  <= '0;
			level_q[1]  <= '0;
			be_q        <= 1'b0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			o_pl_q      <= '0;
			o_pr_q      <= '0;
			o_ol_q      <= '0;
			o_or_q      <= '0;
			o_ml_q      <= '0;
			o_mr_q      <= '0;
			o_mv_q      <= 1'b0;
			o_clip_q    <= 1'b0;
		end else begin
			// Configuration writes; an index past the list has no register
			if (cfg_we) begin
				unique case (cfg_index)
					scsr_pkg::REG_PRE_GAIN:    pre_gain_q    <= cfg_data[23:0];
					scsr_pkg::REG_PRE_PAN:     pre_pan_q     <= cfg_data[16:0];
					scsr_pkg::REG_POST_GAIN:   post_gain_q   <= cfg_data[23:0];
					scsr_pkg::REG_POST_PAN:    post_pan_q    <= cfg_data[16:0];
					scsr_pkg::REG_WIDTH:       width_q       <= cfg_data[16:0];
					scsr_pkg::REG_AUDIBLE:     audible_q     <= cfg_data[0];
					scsr_pkg::REG_RAMP_FRAMES: ramp_frames_q <= cfg_data[RAMP_BITS-1:0];
					scsr_pkg::REG_METER_DECAY: decay_q       <= cfg_data[15:0];
					default: ;
				endcase
			end

			// A finished frame fills the output register; otherwise the beat leaves
			// when the sink does not stall
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)                    out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						l_q    <= AW'(in_left);
						r_q    <= AW'(in_right);
						be_q   <= block_end;
						clip_q <= 1'b0;
						op_q   <= OP_L_GAIN;
						pidx_q <= '0;
						rr_q   <= rr_use;
						// A changed target set starts a new ramp from the current values
						if (apply_targets && changed) begin
							for (int i = 0; i < NP; i++) begin
								start_q[i] <= cur_q[i];
								lat_q[i]   <= tgt[i];
							end
						end
						if (rr_use != '0) begin
							state_q <= S_IMUL;
						end else begin
							for (int i = 0; i < NP; i++) cur_q[i] <= lat_q[i];
							state_q <= S_MUL;
						end
					end
				end
				S_IMUL: begin
					prod_q  <= mul_p;
					state_q <= S_IINIT;
				end
				S_IINIT: begin
					num_q   <= prod_abs[DW-1:0];
					neg_q   <= prod_q[PW-1];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_IDIV;
				end
				S_IDIV: begin
					// One restoring division step per cycle
					rem_q <= qbit ? RAMP_BITS'(trial - {1'b0, rlen}) : trial[RAMP_BITS-1:0];
					num_q <= {num_q[DW-2:0], qbit};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1)) state_q <= S_IFIN;
				end
				S_IFIN: begin
					cur_q[pidx_q] <= interp_v;
					if (pidx_q == 3'(NP - 1)) begin
						state_q <= S_MUL;
					end else begin
						pidx_q  <= pidx_q + 3'd1;
						state_q <= S_IMUL;
					end
				end
				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_MUL;
					op_q    <= op_t'(op_q + 4'd1);
					unique case (op_q) inside
						OP_L_GAIN, OP_L_FADER: l_q <= sh20[AW-1:0];
						OP_R_GAIN, OP_R_FADER: r_q <= sh20[AW-1:0];
						OP_L_PAN, OP_L_MUTE:   l_q <= sh15[AW-1:0];
						OP_R_PAN, OP_R_MUTE:   r_q <= sh15[AW-1:0];
						OP_PRE_L: begin
							pl_q   <= sat_v;
							clip_q <= clip_q | sat_c;
						end
						OP_PRE_R: begin
							pr_q   <= sat_v;
							clip_q <= clip_q | sat_c;
						end
						OP_WIDTH: begin
							l_q <= wid_l[AW-1:0];
							r_q <= wid_r[AW-1:0];
						end
						OP_L_OPAN: begin
							ol_q   <= sat_v;
							clip_q <= clip_q | sat_c;
							if (abs_v > peak_q[0]) peak_q[0] <= abs_v;
						end
						OP_R_OPAN: begin
							or_q   <= sat_v;
							clip_q <= clip_q | sat_c;
							if (abs_v > peak_q[1]) peak_q[1] <= abs_v;
							if (!be_q) state_q <= S_DONE;
						end
						OP_METER_L: begin
							level_q[0] <= (peak_q[0] > dec_v) ? peak_q[0] : dec_v;
							peak_q[0]  <= '0;
						end
						OP_METER_R: begin
							level_q[1] <= (peak_q[1] > dec_v) ? peak_q[1] : dec_v;
							peak_q[1]  <= '0;
							state_q    <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DONE: begin
					// Wait for the output register to be free
					if (!out_valid_q || !out_stall) begin
						o_pl_q      <= pl_q;
						o_pr_q      <= pr_q;
						o_ol_q      <= ol_q;
						o_or_q      <= or_q;
						o_ml_q      <= be_q ? level_q[0] : '0;
						o_mr_q      <= be_q ? level_q[1] : '0;
						o_mv_q      <= be_q;
						o_clip_q    <= clip_q;
						if (rr_q != '0) rr_q <= rr_q - RAMP_BITS'(1);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pre_left    = o_pl_q;
	assign pre_right   = o_pr_q;
	assign post_left   = o_ol_q;
	assign post_right  = o_or_q;
	assign meter_left  = o_ml_q;
	assign meter_right = o_mr_q;
	assign meter_valid = o_mv_q;
	assign clipped     = o_clip_q;

endmodule

// ----- rtl/scsr_checker.sv -----
// Port-level checker for the ramped stereo channel strip, bound to the top level.
// Depends on scsr_pkg and stereo_channel_strip_ramped_macros.svh.
`include "stereo_channel_strip_ramped_macros.svh"

module scsr_checker #(
	parameter int SAMPLE_BITS = scsr_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SAMPLE_BITS-1:0] meter_left,
	input logic [SAMPLE_BITS-1:0] meter_right,
	input logic                   meter_valid
);

	// An accepted frame keeps the block busy for the next cycle.
	`SCSR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "strip took two beats back to back")

	// A new result appears only after a frame was in work.
	`SCSR_ASSERT_NOW(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result without work")

	// Meters read zero on frames that do not end a block.
	`SCSR_ASSERT_NOW(a_meter_zero, clk, arst_n, out_valid && !meter_valid, meter_left == '0 && meter_right == '0, "meter nonzero outside block end")

	// A stalled result beat stays offered.
	`SCSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind stereo_channel_strip_ramped scsr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_scsr_checker (.*);

// ----- tb/stereo_channel_strip_ramped_tb.sv -----
// Self-checking testbench for the ramped stereo channel strip.
// Needs scsr_pkg and the stereo_channel_strip_ramped top level.
`timescale 1ns / 100ps

// Holds the strip's expected behavior and the frames that still await a result.
class strip_scoreboard;
	typedef struct packed {
		logic [23:0] pre_l, pre_r, post_l, post_r, met_l, met_r;
		logic        met_v, clip;
	} frame_out_t;

	longint regs [8];
	longint tgt [6], start_v [6], cur_v [6];
	longint ramp_left;
	longint peak [2], level [2];
	frame_out_t pending [$];
	int errors;

	function new();
		regs[0] = 1048576; regs[1] = 0; regs[2] = 1048576; regs[3] = 0;
		regs[4] = 32768; regs[5] = 1; regs[6] = 240; regs[7] = 63813;
		load_targets(tgt);
		foreach (tgt[i]) begin
			start_v[i] = tgt[i];
			cur_v[i] = tgt[i];
		end
		ramp_left = 0;
		peak[0] = 0; peak[1] = 0; level[0] = 0; level[1] = 0;
		errors = 0;
	endfunction

	function void write_reg(int idx, longint value);
		longint w [8] = '{24, 17, 24, 17, 17, 1, 12, 16};
		if (idx < 8) regs[idx] = value & ((64'd1 << w[idx]) - 1);
	endfunction

	static function longint sx17(longint v);
		return (v & 17'h10000) ? v - 131072 : v;
	endfunction

	static function longint clampv(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function void load_targets(ref longint t [6]);
		t[0] = regs[0];
		t[1] = clampv(sx17(regs[1]), -32768, 32768);
		t[2] = regs[2];
		t[3] = clampv(sx17(regs[3]), -32768, 32768);
		t[4] = clampv(regs[4], 0, 65536);
		t[5] = regs[5][0] ? 32768 : 0;
	endfunction

	// Arithmetic shift is a floor shift; products are exact in 64 bits.
	static function longint mulr(longint a, longint b, int s);
		return (a * b + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	static function longint satv(longint x, ref bit clip);
		if (x > 8388607) begin clip = 1; return 8388607; end
		if (x < -8388608) begin clip = 1; return -8388608; end
		return x;
	endfunction

	// Predict one accepted frame and queue its result.
	function void note_frame(logic [23:0] il, logic [23:0] ir, bit apply, bit bend);
		longint t [6], v [6];
		longint l, r, pl, pr, ol, orr, sm, df, k, big_r;
		bit changed, clip;
		frame_out_t e;
		big_r = regs[6] == 0 ? 1 : regs[6];
		clip = 0;
		if (apply) begin
			load_targets(t);
			changed = 0;
			foreach (t[i]) if (t[i] != tgt[i]) changed = 1;
			if (changed) begin
				foreach (t[i]) begin
					start_v[i] = cur_v[i];
					tgt[i] = t[i];
				end
				ramp_left = big_r;
			end
		end
		if (ramp_left > big_r) ramp_left = big_r;
		foreach (v[i]) begin
			if (ramp_left != 0) begin
				k = big_r - ramp_left + 1;
				v[i] = start_v[i] + ((tgt[i] - start_v[i]) * k) / big_r;
			end else v[i] = tgt[i];
			cur_v[i] = v[i];
		end
		if (ramp_left != 0) ramp_left--;
		l = longint'($signed(il));
		r = longint'($signed(ir));
		l = mulr(l, v[0], 20);
		r = mulr(r, v[0], 20);
		l = mulr(l, 32768 - (v[1] > 0 ? v[1] : 0), 15);
		r = mulr(r, 32768 + (v[1] < 0 ? v[1] : 0), 15);
		pl = satv(mulr(l, v[5], 15), clip);
		pr = satv(mulr(r, v[5], 15), clip);
		if (v[4] != 32768) begin
			sm = (l + r) * 32768;
			df = (l - r) * v[4];
			l = (sm + df + 32768) >>> 16;
			r = (sm - df + 32768) >>> 16;
		end
		l = mulr(mulr(l, v[2], 20), v[5], 15);
		r = mulr(mulr(r, v[2], 20), v[5], 15);
		ol = satv(mulr(l, 32768 - (v[3] > 0 ? v[3] : 0), 15), clip);
		orr = satv(mulr(r, 32768 + (v[3] < 0 ? v[3] : 0), 15), clip);
		if ((ol < 0 ? -ol : ol) > peak[0]) peak[0] = ol < 0 ? -ol : ol;
		if ((orr < 0 ? -orr : orr) > peak[1]) peak[1] = orr < 0 ? -orr : orr;
		e.pre_l = pl[23:0]; e.pre_r = pr[23:0];
		e.post_l = ol[23:0]; e.post_r = orr[23:0];
		e.met_l = '0; e.met_r = '0; e.met_v = 0;
		if (bend) begin
			for (int i = 0; i < 2; i++) begin
				longint dec;
				dec = (level[i] * regs[7]) >>> 16;
				level[i] = peak[i] > dec ? peak[i] : dec;
				peak[i] = 0;
			end
			e.met_l = level[0][23:0]; e.met_r = level[1][23:0]; e.met_v = 1;
		end
		e.clip = clip;
		pending = {pending, e};
	endfunction

	// Compare one accepted result with the oldest expected frame.
	function void check_frame(frame_out_t got);
		frame_out_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result beat %p", got);
			return;
		end
		e = pending.pop_front();
		if (got !== e) begin
			errors++;
			if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
		end
	endfunction
endclass

module stereo_channel_strip_ramped_tb;
	localparam int CW = scsr_pkg::CFG_W;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [23:0] in_left = '0, in_right = '0;
	logic apply_targets = 0, block_end = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [23:0] pre_left, pre_right, post_left, post_right;
	logic [23:0] meter_left, meter_right;
	logic meter_valid, clipped;

	strip_scoreboard sb;
	int send_idle_pct = 0, recv_stall_pct = 0;
	logic hold_active = 0;
	longint cycle_count = 0;

	always #6 clk = ~clk;

	stereo_channel_strip_ramped dut (.*);

	// Receiver: random stall, long hold-off on request, check every result beat.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall)
			sb.check_frame('{pre_left, pre_right, post_left, post_right,
				meter_left, meter_right, meter_valid, clipped});
		if (hold_active) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Timeout guard.
	always @(posedge clk) begin
		if (cycle_count > 3000000) begin
			$display("stereo_channel_strip_ramped_tb: FAIL");
			$finish;
		end
	end

	task automatic write_cfg(input logic [2:0] idx, input logic [CW-1:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(int'(idx), longint'(value));
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offer one frame beat and wait until it is taken; the beat stays offered
	// until the next frame or a drain replaces it.
	task automatic send_frame(input logic [23:0] l, input logic [23:0] r,
		input bit apply, input bit bend);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_left <= l;
		in_right <= r;
		apply_targets <= apply;
		block_end <= bend;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_frame(l, r, apply, bend);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(2047)) - 24'd1024;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic rand_config();
		int p;
		p = $urandom_range(3);
		write_cfg(scsr_pkg::REG_PRE_GAIN,
			p == 0 ? 24'hffffff : 24'($urandom_range(2097152)));
		write_cfg(scsr_pkg::REG_PRE_PAN,
			CW'(p == 1 ? 17'h10000 : 17'($urandom_range(65536)) - 17'd32768));
		write_cfg(scsr_pkg::REG_POST_GAIN,
			p == 2 ? 24'h0 : 24'($urandom_range(2097152)));
		write_cfg(scsr_pkg::REG_POST_PAN,
			CW'(p == 3 ? 17'h1ffff : 17'($urandom_range(65536)) - 17'd32768));
		write_cfg(scsr_pkg::REG_WIDTH,
			CW'($urandom_range(3) == 0 ? 17'h1ffff : 17'($urandom_range(65536))));
		write_cfg(scsr_pkg::REG_AUDIBLE, CW'($urandom_range(3) != 0));
		write_cfg(scsr_pkg::REG_RAMP_FRAMES,
			CW'($urandom_range(4) == 0 ? 12'($urandom) : 12'($urandom_range(12))));
		write_cfg(scsr_pkg::REG_METER_DECAY, CW'(16'($urandom)));
	endtask

	// Random blocks of frames; first frame latches targets, last ends the block.
	task automatic run_blocks(input int frames);
		int n, len;
		n = 0;
		while (n < frames) begin
			len = $urandom_range(1, 16);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0)
					send_frame(rand_sample(), rand_sample(),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					send_frame(rand_sample(), rand_sample(), i == 0, i == len - 1);
				n++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes at reset settings, then mute, extremes and zero ramp.
		send_frame(24'h7fffff, 24'h800000, 0, 0);
		send_frame(24'h800000, 24'h7fffff, 1, 1);
		send_frame(24'h0, 24'h000001, 0, 1);
		drain();
		write_cfg(scsr_pkg::REG_PRE_GAIN, 24'hffffff);
		write_cfg(scsr_pkg::REG_PRE_PAN, CW'(17'h10000));
		write_cfg(scsr_pkg::REG_POST_GAIN, 24'hffffff);
		write_cfg(scsr_pkg::REG_POST_PAN, CW'(17'h08000));
		write_cfg(scsr_pkg::REG_WIDTH, CW'(17'h1ffff));
		write_cfg(scsr_pkg::REG_AUDIBLE, CW'(1'b0));
		write_cfg(scsr_pkg::REG_RAMP_FRAMES, CW'(12'd4));
		write_cfg(scsr_pkg::REG_METER_DECAY, CW'(16'hffff));
		send_frame(24'h7fffff, 24'h800000, 1, 0);
		send_frame(24'h400000, 24'hc00000, 0, 0);
		drain();
		// Shrink the ramp length while a ramp is still running.
		write_cfg(scsr_pkg::REG_RAMP_FRAMES, CW'(12'd1));
		send_frame(24'h7fffff, 24'h7fffff, 0, 1);
		send_frame(24'h123456, 24'h800000, 1, 1);
		drain();
		write_cfg(scsr_pkg::REG_RAMP_FRAMES, CW'(12'd0));
		write_cfg(scsr_pkg::REG_AUDIBLE, CW'(1'b1));
		write_cfg(scsr_pkg::REG_PRE_PAN, CW'(17'h18000));
		write_cfg(scsr_pkg::REG_POST_PAN, CW'(17'h17fff));
		write_cfg(scsr_pkg::REG_METER_DECAY, CW'(16'h0));
		send_frame(24'h7fffff, 24'h800000, 1, 1);
		send_frame(24'h800000, 24'h800000, 1, 1);
		send_frame(24'h000100, 24'hffff00, 0, 1);
		drain();

		// Random phases under the four idling patterns.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			rand_config();
			// Long receiver hold-off, counted in its own process.
			if (ph == 2) begin
				fork
					begin
						hold_active <= 1;
						repeat (3000) @(posedge clk);
						hold_active <= 0;
					end
				join_none
			end
			run_blocks(140);
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("stereo_channel_strip_ramped_tb: PASS");
		else
			$display("stereo_channel_strip_ramped_tb: FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scsr_pkg.sv
rtl/stereo_channel_strip_ramped.sv
rtl/scsr_checker.sv
tb/stereo_channel_strip_ramped_tb.sv
